// ===== hdl/fcd_pkg.sv =====
// Shared constants, types and helpers for the centroid defuzzifier.
`timescale 1ns / 1ps

package fcd_pkg;

   localparam int POINT_WIDTH          = 16;
   localparam int MEMBERSHIP_FRAC_BITS = 16;

   localparam int MEM_W   = MEMBERSHIP_FRAC_BITS + 1;
   localparam int DIFF_W  = POINT_WIDTH + 1;
   localparam int MSUM_W  = MEMBERSHIP_FRAC_BITS + 2;
   localparam int TERM_W  = DIFF_W + MSUM_W + 1;
   localparam int MOM_W   = TERM_W + DIFF_W;
   localparam int ACC_W   = 64;
   localparam int MAG_W   = ACC_W - 1;
   localparam int DCNT_W  = $clog2(MAG_W + 1);
   localparam int STATUS_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int REQ_DATA_W = ((POINT_WIDTH + MEM_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((POINT_WIDTH + STATUS_W + 7) / 8) * 8;

   localparam logic [MEM_W-1:0] MEM_ONE = MEM_W'(1) << MEMBERSHIP_FRAC_BITS;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

   localparam logic [MAG_W-1:0] CEN_NEG_LIM = MAG_W'(1) << (POINT_WIDTH - 1);
   localparam logic [MAG_W-1:0] CEN_POS_LIM = CEN_NEG_LIM - MAG_W'(1);
   localparam logic [POINT_WIDTH-1:0] CEN_MAX = {1'b0, {(POINT_WIDTH-1){1'b1}}};
   localparam logic [POINT_WIDTH-1:0] CEN_MIN = {1'b1, {(POINT_WIDTH-1){1'b0}}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_AREA = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // one classified item as handed from the front to the back
   typedef struct packed {
      logic signed [DIFF_W-1:0] diff;   // x - previous x
      logic [MSUM_W-1:0]        msum;   // membership + previous membership
      logic signed [DIFF_W-1:0] xsum;   // x + previous x (x itself on the first item)
      logic                     pair;   // a previous item exists in this set
      logic                     last;
   } pair_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] sum;
      logic                    ovf;
   } sat_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] dividend;
      logic [MAG_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] quotient;
   } div_rsp_type;

   // add clamped symmetrically to +-ACC_MAX
   function automatic sat_type sat_add(input logic signed [ACC_W-1:0] a,
                                       input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      logic signed [ACC_W:0] hi;
      logic signed [ACC_W:0] lo;
      sat_type               r;
      s     = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
      hi    = $signed({1'b0, ACC_MAX});
      lo    = -hi;
      r.sum = s[ACC_W-1:0];
      r.ovf = 1'b0;
      if (s > hi) begin
         r.sum = ACC_MAX;
         r.ovf = 1'b1;
      end else if (s < lo) begin
         r.sum = -ACC_MAX;
         r.ovf = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== hdl/fuzzy_centroid_defuzzifier.sv =====
// Top level of the centroid defuzzifier: front, queue, accumulate back end and divider.
`timescale 1ns / 1ps

//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: point_value, membership; tlast: last_point
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: centroid, status
//
//  Items are taken one per cycle while the four-entry queue has room; each pair passes
//  a two-multiplier accumulate pipeline. The last item of a set closes it, directly for
//  a lone point or zero area, else through the 63-step restoring divider; the next set
//  waits in the queue.
//  The result register lets the back end finish while the consumer stalls.
//  Reset is synchronous and active high and clears all set state at once.

module fuzzy_centroid_defuzzifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fcd_pkg::REQ_DATA_W-1:0]     req_tdata,   // point_value, membership, zero pad
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fcd_pkg::RSP_DATA_W-1:0]     rsp_tdata    // centroid, status, zero pad
);

   fcd_pkg::pair_type    push_entry;
   fcd_pkg::pair_type    pop_entry;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_empty;
   fcd_pkg::div_req_type div_req;
   fcd_pkg::div_rsp_type div_rsp;

   fcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   fcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   fcd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/fcd_front.sv =====
// Front end: accepts items, clamps membership and pairs each item with the previous one.
`timescale 1ns / 1ps

module fcd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fcd_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tlast,
   input  logic                                q_full,
   output logic                                q_push,
   output fcd_pkg::pair_type                   q_entry
);

   logic signed [fcd_pkg::POINT_WIDTH-1:0] prev_point_ff, prev_point_in;
   logic [fcd_pkg::MEM_W-1:0]              prev_mem_ff, prev_mem_in;
   logic                                   have_prev_ff, have_prev_in;

   logic signed [fcd_pkg::POINT_WIDTH-1:0] x;
   logic [fcd_pkg::MEM_W-1:0]              mem_raw;
   logic [fcd_pkg::MEM_W-1:0]              mem_clamp;
   logic                                   accept;

   assign x         = $signed(req_tdata[fcd_pkg::POINT_WIDTH-1:0]);
   assign mem_raw   = req_tdata[fcd_pkg::POINT_WIDTH +: fcd_pkg::MEM_W];
   assign mem_clamp = (mem_raw > fcd_pkg::MEM_ONE) ? fcd_pkg::MEM_ONE : mem_raw;

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & ~q_full;
   assign q_push     = accept;

   assign q_entry.diff = $signed({x[fcd_pkg::POINT_WIDTH-1], x})
                       - $signed({prev_point_ff[fcd_pkg::POINT_WIDTH-1], prev_point_ff});
   assign q_entry.xsum = $signed({x[fcd_pkg::POINT_WIDTH-1], x})
                       + $signed({prev_point_ff[fcd_pkg::POINT_WIDTH-1], prev_point_ff});
   assign q_entry.msum = {1'b0, mem_clamp} + {1'b0, prev_mem_ff};
   assign q_entry.pair = have_prev_ff;
   assign q_entry.last = req_tlast;

   // previous point stays zero between sets so xsum carries the lone point
   always_comb begin
      prev_point_in = prev_point_ff;
      prev_mem_in   = prev_mem_ff;
      have_prev_in  = have_prev_ff;
      if (accept) begin
         if (req_tlast) begin
            prev_point_in = '0;
            prev_mem_in   = '0;
            have_prev_in  = 1'b0;
         end else begin
            prev_point_in = x;
            prev_mem_in   = mem_clamp;
            have_prev_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_point_ff <= '0;
         prev_mem_ff   <= '0;
         have_prev_ff  <= 1'b0;
      end else begin
         prev_point_ff <= prev_point_in;
         prev_mem_ff   <= prev_mem_in;
         have_prev_ff  <= have_prev_in;
      end
   end

endmodule

// ===== hdl/fcd_queue.sv =====
// Short register queue between the front and the back.
`timescale 1ns / 1ps

module fcd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fcd_pkg::pair_type push_entry,
   output logic              full,
   input  logic              pop,
   output fcd_pkg::pair_type pop_entry,
   output logic              empty
);

   fcd_pkg::pair_type               entry_ff [fcd_pkg::QUEUE_DEPTH];
   logic [fcd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fcd_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fcd_pkg::QPTR_W:0]        count_ff, count_in;

   assign full      = (count_ff == (fcd_pkg::QPTR_W + 1)'(fcd_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fcd_pkg::QPTR_W'(fcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fcd_pkg::QPTR_W'(fcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/fcd_div.sv =====
// Restoring divider for the accumulator magnitudes, one quotient bit a cycle.
`timescale 1ns / 1ps

module fcd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fcd_pkg::div_req_type div_req,
   output fcd_pkg::div_rsp_type div_rsp
);

   logic [fcd_pkg::MAG_W:0]    rem_ff, rem_in;
   logic [fcd_pkg::MAG_W-1:0]  quo_ff, quo_in;
   logic [fcd_pkg::MAG_W-1:0]  dvs_ff, dvs_in;
   logic [fcd_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                       done_ff, done_in;

   logic [fcd_pkg::MAG_W:0]    trial;
   logic [fcd_pkg::MAG_W+1:0]  diff;

   assign trial = {rem_ff[fcd_pkg::MAG_W-1:0], quo_ff[fcd_pkg::MAG_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         quo_in = div_req.dividend;
         dvs_in = div_req.divisor;
         cnt_in = fcd_pkg::DCNT_W'(fcd_pkg::MAG_W);
      end else if (cnt_ff != '0) begin
         // dividend bits shift out of the top of quo while quotient bits enter below
         if (!diff[fcd_pkg::MAG_W+1]) begin
            rem_in = diff[fcd_pkg::MAG_W:0];
            quo_in = {quo_ff[fcd_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[fcd_pkg::MAG_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == fcd_pkg::DCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== hdl/fcd_back.sv =====
// Back end: trapezoid multiply-accumulate pipeline, end-of-set control and result register.
`timescale 1ns / 1ps

module fcd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  fcd_pkg::pair_type                  q_entry,
   output logic                               q_pop,
   output fcd_pkg::div_req_type               div_req,
   input  fcd_pkg::div_rsp_type               div_rsp,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fcd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FIN,
      ST_DIV,
      ST_OUT
   } state_type;

   localparam int PW = fcd_pkg::POINT_WIDTH;

   state_type                             state_ff, state_in;
   logic                                  hold_ff, hold_in;

   logic                                  s1_valid_ff, s1_valid_in;
   logic signed [fcd_pkg::TERM_W-1:0]     s1_term_ff, s1_term_in;
   logic signed [fcd_pkg::DIFF_W-1:0]     s1_xsum_ff, s1_xsum_in;
   logic                                  s1_pair_ff, s1_pair_in;
   logic                                  s1_last_ff, s1_last_in;

   logic                                  s2_valid_ff, s2_valid_in;
   logic signed [fcd_pkg::MOM_W-1:0]      s2_mom_ff, s2_mom_in;
   logic signed [fcd_pkg::DIFF_W-1:0]     s2_xsum_ff, s2_xsum_in;
   logic                                  s2_pair_ff, s2_pair_in;
   logic                                  s2_last_ff, s2_last_in;

   logic signed [fcd_pkg::ACC_W-1:0]      area_ff, area_in;
   logic signed [fcd_pkg::ACC_W-1:0]      moment_ff, moment_in;
   logic                                  ovf_ff, ovf_in;

   logic                                  fin_single_ff, fin_single_in;
   logic [PW-1:0]                         fin_point_ff, fin_point_in;
   logic [PW-1:0]                         res_cen_ff, res_cen_in;
   fcd_pkg::status_type                   res_status_ff, res_status_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                         rsp_cen_ff, rsp_cen_in;
   fcd_pkg::status_type                   rsp_status_ff, rsp_status_in;

   fcd_pkg::sat_type                      area_add;
   fcd_pkg::sat_type                      mom_add;
   logic signed [fcd_pkg::ACC_W-1:0]      neg_moment;
   logic signed [fcd_pkg::ACC_W-1:0]      neg_area;
   logic                                  cen_neg;
   logic [fcd_pkg::MAG_W-1:0]             q_half;
   logic [PW-1:0]                         div_cen;
   logic                                  out_load;

   assign q_pop = (state_ff == ST_RUN) && !hold_ff && !q_empty;

   assign s1_term_in = q_entry.diff * $signed({1'b0, q_entry.msum});
   assign s2_mom_in  = s1_term_ff * s1_xsum_ff;

   assign area_add = fcd_pkg::sat_add(area_ff, fcd_pkg::ACC_W'(s1_term_ff));
   assign mom_add  = fcd_pkg::sat_add(moment_ff, fcd_pkg::ACC_W'(s2_mom_ff));

   // sums never reach the most negative code, so magnitudes fit MAG_W bits
   assign neg_moment = -moment_ff;
   assign neg_area   = -area_ff;
   assign cen_neg    = moment_ff[fcd_pkg::ACC_W-1] ^ area_ff[fcd_pkg::ACC_W-1];

   assign div_req.start    = (state_ff == ST_FIN) && !fin_single_ff && (area_ff != '0);
   assign div_req.dividend = moment_ff[fcd_pkg::ACC_W-1] ?
                             neg_moment[fcd_pkg::MAG_W-1:0] : moment_ff[fcd_pkg::MAG_W-1:0];
   assign div_req.divisor  = area_ff[fcd_pkg::ACC_W-1] ?
                             neg_area[fcd_pkg::MAG_W-1:0] : area_ff[fcd_pkg::MAG_W-1:0];

   // area is doubled and moment quadrupled, hence the extra halving
   assign q_half = div_rsp.quotient >> 1;

   always_comb begin
      if (!cen_neg) begin
         div_cen = (q_half > fcd_pkg::CEN_POS_LIM) ? fcd_pkg::CEN_MAX : q_half[PW-1:0];
      end else begin
         div_cen = (q_half > fcd_pkg::CEN_NEG_LIM) ? fcd_pkg::CEN_MIN : -q_half[PW-1:0];
      end
   end

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      hold_in       = hold_ff;
      area_in       = area_ff;
      moment_in     = moment_ff;
      ovf_in        = ovf_ff;
      fin_single_in = fin_single_ff;
      fin_point_in  = fin_point_ff;
      res_cen_in    = res_cen_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_cen_in    = rsp_cen_ff;
      rsp_status_in = rsp_status_ff;

      s1_valid_in = q_pop;
      s1_xsum_in  = q_entry.xsum;
      s1_pair_in  = q_entry.pair;
      s1_last_in  = q_entry.last;

      s2_valid_in = s1_valid_ff;
      s2_xsum_in  = s1_xsum_ff;
      s2_pair_in  = s1_pair_ff;
      s2_last_in  = s1_last_ff;

      if (s1_valid_ff && s1_pair_ff) begin
         area_in = area_add.sum;
         ovf_in  = ovf_in | area_add.ovf;
      end
      if (s2_valid_ff && s2_pair_ff) begin
         moment_in = mom_add.sum;
         ovf_in    = ovf_in | mom_add.ovf;
      end
      // nothing of the next set enters until this set's result is out
      if (q_pop && q_entry.last) begin
         hold_in = 1'b1;
      end

      case (state_ff)
         ST_RUN: begin
            if (s2_valid_ff && s2_last_ff) begin
               state_in      = ST_FIN;
               fin_single_in = !s2_pair_ff;
               fin_point_in  = s2_xsum_ff[PW-1:0];
            end
         end
         ST_FIN: begin
            if (fin_single_ff) begin
               res_cen_in    = fin_point_ff;
               res_status_in = fcd_pkg::STATUS_OK;
               state_in      = ST_OUT;
            end else if (area_ff == '0) begin
               res_cen_in    = '0;
               res_status_in = ovf_ff ? fcd_pkg::STATUS_OVERFLOW : fcd_pkg::STATUS_ZERO_AREA;
               state_in      = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_cen_in    = div_cen;
               res_status_in = ovf_ff ? fcd_pkg::STATUS_OVERFLOW : fcd_pkg::STATUS_OK;
               state_in      = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_cen_in    = res_cen_ff;
               rsp_status_in = res_status_ff;
               area_in       = '0;
               moment_in     = '0;
               ovf_in        = 1'b0;
               hold_in       = 1'b0;
               state_in      = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s1_term_ff    <= s1_term_in;
      s1_xsum_ff    <= s1_xsum_in;
      s1_pair_ff    <= s1_pair_in;
      s1_last_ff    <= s1_last_in;
      s2_mom_ff     <= s2_mom_in;
      s2_xsum_ff    <= s2_xsum_in;
      s2_pair_ff    <= s2_pair_in;
      s2_last_ff    <= s2_last_in;
      fin_single_ff <= fin_single_in;
      fin_point_ff  <= fin_point_in;
      res_cen_ff    <= res_cen_in;
      res_status_ff <= res_status_in;
      rsp_cen_ff    <= rsp_cen_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_RUN;
         hold_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         area_ff      <= '0;
         moment_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_ff      <= hold_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         area_ff      <= area_in;
         moment_ff    <= moment_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(fcd_pkg::RSP_DATA_W - PW - fcd_pkg::STATUS_W)'(0),
                        rsp_status_ff, rsp_cen_ff};

`ifndef SYNTHESIS
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (area_ff != '0))
      else $error("divider started with zero area");

   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("item in flight after end of set");

   a_clear_on_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (area_ff == '0 && moment_ff == '0 && !ovf_ff && rsp_valid_ff))
      else $error("set state not cleared when result loaded");

   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (hold_ff && $past(hold_ff)) |-> !s1_valid_ff)
      else $error("item entered the pipeline while a set was closing");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the centroid defuzzifier: directed sets, random sets, backpressure.
`timescale 1ns / 1ps

module tb;

   localparam int PW = fcd_pkg::POINT_WIDTH;
   localparam int MW = fcd_pkg::MEM_W;

   localparam longint MEM_FULL = 64'sd1 <<< fcd_pkg::MEMBERSHIP_FRAC_BITS;
   localparam longint ACC_LIM  = 64'sh7fff_ffff_ffff_ffff;
   localparam longint CEN_HI   = (64'sd1 <<< (PW - 1)) - 1;
   localparam longint CEN_LO   = -CEN_HI - 1;

   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam longint TIMEOUT_NS = 64'd5_000_000;

   typedef struct packed {
      logic [PW-1:0]       centroid;
      fcd_pkg::status_type status;
   } centroid_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [fcd_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // point_value, membership, zero pad
   logic                          req_tlast = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [fcd_pkg::RSP_DATA_W-1:0] rsp_tdata;       // centroid, status, zero pad

   // expected centroids, oldest first
   centroid_result_type centroid_q[$];
   int               mismatch_count  = 0;
   int               items_sent      = 0;
   int               send_idle_pct   = 0;
   int               recv_idle_pct   = 0;
   int               hold_requests   = 0;
   int               hold_taken      = 0;
   int               hold_left       = 0;

   // running state of the set being received
   longint prev_x;
   longint prev_m;
   bit     have_prev;
   longint area_acc;
   longint moment_acc;
   bit     acc_ovf;

   fuzzy_centroid_defuzzifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint clamp_add(input longint a, input longint b);
      logic signed [64:0] s;
      s = a + b;
      if (s > ACC_LIM) begin
         acc_ovf = 1'b1;
         return ACC_LIM;
      end
      if (s < -ACC_LIM) begin
         acc_ovf = 1'b1;
         return -ACC_LIM;
      end
      return longint'(s);
   endfunction

   function automatic longint clamp_mul(input longint a, input longint b);
      logic signed [127:0] p;
      p = a * b;
      if (p > ACC_LIM) begin
         acc_ovf = 1'b1;
         return ACC_LIM;
      end
      if (p < -ACC_LIM) begin
         acc_ovf = 1'b1;
         return -ACC_LIM;
      end
      return longint'(p);
   endfunction

   function automatic void clear_set_state();
      prev_x     = 0;
      prev_m     = 0;
      have_prev  = 1'b0;
      area_acc   = 0;
      moment_acc = 0;
      acc_ovf    = 1'b0;
   endfunction

   // trapezoid accumulate; the set closes on its last item
   function automatic void predict_element(input logic signed [PW-1:0] pt,
                                           input logic [MW-1:0] mem_in, input bit last);
      longint              x;
      longint              m;
      longint              t;
      longint              g;
      longint              cen;
      fcd_pkg::status_type st;
      centroid_result_type exp_item;
      x   = pt;
      m   = mem_in;
      cen = 0;
      st  = fcd_pkg::STATUS_OK;
      if (m > MEM_FULL)
         m = MEM_FULL;
      if (have_prev) begin
         t          = clamp_mul(x - prev_x, m + prev_m);
         g          = clamp_mul(t, x + prev_x);
         area_acc   = clamp_add(area_acc, t);
         moment_acc = clamp_add(moment_acc, g);
      end
      if (!last) begin
         prev_x    = x;
         prev_m    = m;
         have_prev = 1'b1;
         return;
      end
      if (!have_prev) begin
         cen = x;
      end else begin
         if (area_acc == 0) begin
            st = fcd_pkg::STATUS_ZERO_AREA;
         end else begin
            cen = (moment_acc / area_acc) / 2;
         end
         if (acc_ovf)
            st = fcd_pkg::STATUS_OVERFLOW;
      end
      if (cen > CEN_HI)
         cen = CEN_HI;
      if (cen < CEN_LO)
         cen = CEN_LO;
      exp_item.centroid = cen[PW-1:0];
      exp_item.status   = st;
      centroid_q.insert(centroid_q.size(), exp_item);
      clear_set_state();
   endfunction

   function automatic logic [MW-1:0] rand_membership();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return MW'(MEM_FULL);
         2: return MW'($urandom_range(int'(MEM_FULL) + 1, (1 << MW) - 1));
         default: return MW'($urandom_range(0, int'(MEM_FULL)));
      endcase
   endfunction

   // one item; called at a rising edge, returns at the edge that accepted it
   task automatic send_element(input logic signed [PW-1:0] pt, input logic [MW-1:0] mem,
                               input bit last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= fcd_pkg::REQ_DATA_W'({mem, pt});
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_element(pt, mem, last);
      items_sent++;
   endtask

   always @(posedge clock) begin : result_check
      centroid_result_type got;
      centroid_result_type want;
      got.centroid = rsp_tdata[PW-1:0];
      got.status   = fcd_pkg::status_type'(rsp_tdata[PW +: fcd_pkg::STATUS_W]);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (centroid_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual centroid %0d status %0d",
                     $time, $signed(got.centroid), got.status);
            mismatch_count++;
         end else begin
            want = centroid_q.pop_front();
            if (got.centroid !== want.centroid) begin
               $display("%0t: centroid expected %0d actual %0d", $time,
                        $signed(want.centroid), $signed(got.centroid));
               mismatch_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
               mismatch_count++;
            end
         end
      end
   end

   // consumer readiness: random idling, and a long hold-off whenever one is requested
   always @(posedge clock) begin : receiver
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_taken != hold_requests) begin
         hold_taken = hold_requests;
         hold_left  = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic test_single_points();
      send_element(-16'sd32768, MW'(MEM_FULL), 1'b1);
      send_element(16'sd32767, '0, 1'b1);
   endtask

   // membership above one is clamped
   task automatic test_basic_sets();
      send_element(-16'sd32768, MW'(MEM_FULL), 1'b0);
      send_element(16'sd0, {MW{1'b1}}, 1'b0);
      send_element(16'sd32767, '0, 1'b1);
   endtask

   task automatic test_zero_area();
      send_element(16'sd5, '0, 1'b0);
      send_element(16'sd10, '0, 1'b1);
      send_element(16'sd300, MW'(40000), 1'b0);
      send_element(16'sd300, MW'(MEM_FULL), 1'b1);
   endtask

   task automatic test_out_of_order_points();
      send_element(16'sd100, MW'(MEM_FULL), 1'b0);
      send_element(-16'sd100, MW'(30000), 1'b1);
   endtask

   // opposing small areas far apart push the quotient past the point range
   task automatic test_saturated_centroid();
      send_element(16'sd32766, '0, 1'b0);
      send_element(16'sd32767, MW'(2), 1'b0);
      send_element(16'sd32767, '0, 1'b0);
      send_element(-16'sd32767, '0, 1'b0);
      send_element(-16'sd32767, MW'(1), 1'b0);
      send_element(-16'sd32768, '0, 1'b1);
      send_element(-16'sd32766, '0, 1'b0);
      send_element(-16'sd32767, MW'(2), 1'b0);
      send_element(-16'sd32767, '0, 1'b0);
      send_element(16'sd32766, '0, 1'b0);
      send_element(16'sd32766, MW'(1), 1'b0);
      send_element(16'sd32767, '0, 1'b1);
   endtask

   task automatic test_random_sets(input int n_items, input int s_idle, input int r_idle);
      int target;
      int kind;
      int len;
      int cur;
      int base;
      bit same_point;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      target        = items_sent + n_items;
      while (items_sent < target) begin
         kind = $urandom_range(0, 99);
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
         if (kind < 70) begin
            // well-formed: ascending points
            cur = int'($urandom_range(0, 65535)) - 32768;
            for (int i = 0; i < len; i++) begin
               send_element(PW'(cur), rand_membership(), i == len - 1);
               cur += $urandom_range(0, (32767 - cur) / len);
            end
         end else if (kind < 80) begin
            same_point = $urandom_range(0, 1);
            base       = $urandom_range(0, 65535);
            for (int i = 0; i < len; i++) begin
               if (same_point)
                  send_element(PW'(base), rand_membership(), i == len - 1);
               else
                  send_element(PW'($urandom_range(0, 65535)), '0, i == len - 1);
            end
         end else if (kind < 95) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               send_element(PW'($urandom_range(0, 65535)),
                            MW'($urandom_range(0, (1 << MW) - 1)), i == len - 1);
         end else begin
            send_element(PW'($urandom_range(0, 65535)), rand_membership(), 1'b1);
         end
      end
   endtask

   // consumer stalls long enough for the queue and result register to fill
   task automatic test_backpressure();
      int len;
      int cur;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      for (int s = 0; s < 40; s++) begin
         len = $urandom_range(1, 3);
         cur = int'($urandom_range(0, 65535)) - 32768;
         for (int i = 0; i < len; i++) begin
            send_element(PW'(cur), rand_membership(), i == len - 1);
            cur += $urandom_range(0, (32767 - cur) / len);
         end
      end
   endtask

   initial begin
      clear_set_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 7;
      recv_idle_pct = 61;
      test_single_points();
      test_basic_sets();
      test_zero_area();
      test_out_of_order_points();
      test_saturated_centroid();
      test_random_sets(600, 7, 61);
      test_random_sets(600, 61, 7);
      test_backpressure();
      test_random_sets(450, 0, 0);
      req_tvalid    <= 1'b0;
      req_tlast     <= 1'b0;
      recv_idle_pct = 0;
      while (centroid_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/fcd_pkg.sv
hdl/fcd_front.sv
hdl/fcd_queue.sv
hdl/fcd_div.sv
hdl/fcd_back.sv
hdl/fuzzy_centroid_defuzzifier.sv
test/tb.sv
